// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the blink frequency filter; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, switched off while the given reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion on the module's own clock and reset.
`define ASSERT_ON(label, prop, msg) \
   `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ----- src/ebff_pkg.sv -----
// Package with the types and constants of the event blink frequency filter.
`timescale 1ns / 1ps

package ebff_pkg;

   localparam int COORD_W   = 7;
   localparam int STAMP_W   = 32;
   localparam int ENTRY_W   = 2 * STAMP_W;
   localparam int EVENT_W   = 2 * COORD_W + STAMP_W + 1;
   localparam int TDATA_W   = ((EVENT_W + 7) / 8) * 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_PERIOD     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PERIOD_TOLERANCE = 1'd1;

   localparam logic [STAMP_W-1:0] BLINK_PERIOD_RESET     = 32'd1000;
   localparam logic [STAMP_W-1:0] PERIOD_TOLERANCE_RESET = 32'd100;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int COUNT_W    = 3;

   // Packed with the column in the lowest bits.
   typedef struct packed {
      logic               polarity;
      logic [STAMP_W-1:0] stamp;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
   } event_type;

endpackage

// ----- src/ebff_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module ebff_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/event_blink_frequency_filter.sv -----
// Top level of the event blink frequency filter: per-pixel timestamp store and interval test.
//
// Channel  Direction  Handshake               Content
// req      in         req_tvalid/req_tready   one camera event
// rsp      out        rsp_tvalid/rsp_tready   the event when it passes the test
// csr      in         csr_we                  blink period and tolerance
//
// Events enter one per cycle while req_tready is high; passed ones go via s1, s2 and the queue.
// The throughput is set by the single read-modify-write of the timestamp RAM per event.
// After reset a clearing pass zeroes all COLUMNS*ROWS entries of the RAM, one entry per cycle.
// A four-entry queue absorbs stalls on rsp; req stalls once it could fill and during the clear.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module event_blink_frequency_filter import ebff_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int ROWS    = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0: in_column, in_row, in_time, in_polarity, zero fill.
   input  logic [TDATA_W-1:0]     req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: out_column, out_row, out_time, out_polarity, zero fill.
   output logic [TDATA_W-1:0]     rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PIXELS = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(PIXELS);

   function automatic logic [STAMP_W-1:0] magnitude(input logic [STAMP_W-1:0] d);
      return d[STAMP_W-1] ? (STAMP_W'(0) - d) : d;
   endfunction

   logic [STAMP_W-1:0] period_ff;
   logic [STAMP_W-1:0] tolerance_ff;

   logic               clear_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;

   event_type          req_event;
   logic               req_in_range;
   logic [ADDR_W-1:0]  req_addr;
   logic               req_accept;

   logic               s1_valid_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   event_type          s1_event_ff;
   logic               fwd_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;
   logic [ENTRY_W-1:0] s1_entry;
   logic [STAMP_W-1:0] s1_last;
   logic [STAMP_W-1:0] s1_prior;

   logic               s2_valid_ff;
   event_type          s2_event_ff;
   logic [STAMP_W-1:0] s2_dev_last_ff;
   logic [STAMP_W-1:0] s2_dev_prior_ff;
   logic               s2_pass;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;

   event_type          fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] inflight;
   logic               push;
   logic               pop;

   assign req_event    = event_type'(req_tdata[EVENT_W-1:0]);
   assign req_in_range = (32'(req_event.column) < COLUMNS) && (32'(req_event.row) < ROWS);
   assign req_addr     = ADDR_W'(req_event.column) +
                         ADDR_W'(req_event.row) * ADDR_W'(COLUMNS);

   assign inflight   = count_ff + COUNT_W'(s1_valid_ff) + COUNT_W'(s2_valid_ff);
   assign req_tready = !clear_ff && (inflight < COUNT_W'(FIFO_DEPTH));
   assign req_accept = req_tvalid && req_tready;

   // The entry holds the prior stamp in the upper half and the last stamp in the lower half.
   assign s1_entry = fwd_ff ? fwd_data_ff : ram_rdata;
   assign s1_last  = s1_entry[STAMP_W-1:0];
   assign s1_prior = s1_entry[ENTRY_W-1:STAMP_W];

   assign ram_we    = clear_ff || s1_valid_ff;
   assign ram_waddr = clear_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wdata = clear_ff ? '0 : {s1_last, s1_event_ff.stamp};

   ebff_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PIXELS)
   ) u_stamp_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (req_addr),
      .rdata (ram_rdata)
   );

   assign s2_pass = (magnitude(s2_dev_last_ff) < tolerance_ff) &&
                    (magnitude(s2_dev_prior_ff) < tolerance_ff);

   assign push       = s2_valid_ff && s2_pass;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = TDATA_W'(fifo_ff[rd_ptr_ff]);

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + COUNT_W'(1);
         2'b01:   count_in = count_ff - COUNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= BLINK_PERIOD_RESET;
         tolerance_ff <= PERIOD_TOLERANCE_RESET;
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_BLINK_PERIOD:     period_ff    <= csr_wdata;
               REG_PERIOD_TOLERANCE: tolerance_ff <= csr_wdata;
               default:              period_ff    <= period_ff;
            endcase
         end
         if (clear_ff) begin
            if (clr_addr_ff == ADDR_W'(PIXELS - 1)) begin
               clear_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            end
         end
         s1_valid_ff <= req_accept && req_in_range;
         s2_valid_ff <= s1_valid_ff;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      // A new read of the entry that stage one is writing now would see stale data.
      fwd_ff          <= s1_valid_ff && (s1_addr_ff == req_addr);
      fwd_data_ff     <= ram_wdata;
      s1_addr_ff      <= req_addr;
      s1_event_ff     <= req_event;
      s2_event_ff     <= s1_event_ff;
      s2_dev_last_ff  <= s1_event_ff.stamp - s1_last - period_ff;
      s2_dev_prior_ff <= s1_last - s1_prior - period_ff;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= s2_event_ff;
      end
   end

   `ASSERT_ON(inflight_bound, inflight <= COUNT_W'(FIFO_DEPTH), "Output queue can overflow.")
   `ASSERT_ON(idle_while_clearing, clear_ff |-> (!s1_valid_ff && !s2_valid_ff),
              "Event in flight during clearing pass.")
   `ASSERT_ON(clear_sweep_complete,
              $fell(clear_ff) |-> ($past(clr_addr_ff) == ADDR_W'(PIXELS - 1)),
              "Clearing pass ended early.")
   `ASSERT_ON(forward_matches_write,
              (s1_valid_ff && fwd_ff) |->
                 ($past(ram_we && !clear_ff) && ($past(ram_waddr) == s1_addr_ff)),
              "Forwarded entry does not match the last write.")

endmodule
